### src/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Constants and the control byte decoder for the display frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfr_pkg;

	localparam logic [7:0] START_BYTE  = 8'h59;
	localparam logic [7:0] ASSIST_MASK = 8'h5E;
	localparam int         LIGHT_BIT   = 0;
	localparam int         WALK_BIT    = 5;

	localparam logic [7:0] CODE_X0  = 8'h10;
	localparam logic [7:0] CODE_X10 = 8'h40;
	localparam logic [7:0] CODE_X20 = 8'h02;
	localparam logic [7:0] CODE_X30 = 8'h04;
	localparam logic [7:0] CODE_X40 = 8'h08;

	localparam logic [5:0] FACTOR_X0  = 6'd0;
	localparam logic [5:0] FACTOR_X10 = 6'd10;
	localparam logic [5:0] FACTOR_X20 = 6'd20;
	localparam logic [5:0] FACTOR_X30 = 6'd30;
	localparam logic [5:0] FACTOR_X40 = 6'd40;

	typedef struct packed {
		logic       hit;
		logic [5:0] factor;
	} assist_dec_t;

	// Maps the masked control byte to an assist factor; an unknown code clears the hit flag and returns factor zero.
	function automatic assist_dec_t decode_assist(input logic [7:0] ctrl);
		assist_dec_t d;
		d.hit    = 1'b1;
		d.factor = FACTOR_X0;
		case (ctrl & ASSIST_MASK)
			CODE_X0:  d.factor = FACTOR_X0;
			CODE_X10: d.factor = FACTOR_X10;
			CODE_X20: d.factor = FACTOR_X20;
			CODE_X30: d.factor = FACTOR_X30;
			CODE_X40: d.factor = FACTOR_X40;
			default:  d.hit = 1'b0;
		endcase
		return d;
	endfunction

endpackage

### src/display_frame_receiver.sv
// ----------------------------------------------------------------------------
// display_frame_receiver
// Hunts for the start byte, collects a frame, checks its sum byte and decodes
// the assist, lights and walk assist commands from the control byte.
// Timing: an accepted byte waits in the input register and is processed once
// the output register is free; a frame's last byte then loads the result.
// Throughput: one byte per cycle; the input register only waits while a
// finished result is held in the output register and not yet taken.
// Reset: all control state clears; the receiver starts out hunting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module display_frame_receiver #(
	parameter int FRAME_LEN = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       frame_ok,
	output logic [5:0] assist_factor_x10,
	output logic       lights_on,
	output logic       walk_assist_on
);

	localparam int              IDX_W    = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0] CTRL_IDX = IDX_W'(1);

	logic             valid_s1;
	logic [7:0]       byte_s1;

	logic             in_frame_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       ctrl_q;
	logic [5:0]       assist_q;
	logic             lights_q;
	logic             walk_q;

	logic             res_valid_q;
	logic             ok_q;

	logic             out_free;
	logic             step;
	logic             frame_end;
	logic             sum_match;
	dfr_pkg::assist_dec_t dec;

	assign out_free  = !res_valid_q || res_ready;
	assign step      = valid_s1 && out_free;
	assign rx_ready  = !valid_s1 || out_free;
	assign frame_end = in_frame_q && (idx_q == LAST_IDX);
	assign sum_match = (byte_s1 == sum_q);
	assign dec       = dfr_pkg::decode_assist(ctrl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			idx_q       <= '0;
			sum_q       <= '0;
			ctrl_q      <= '0;
			assist_q    <= dfr_pkg::FACTOR_X0;
			lights_q    <= 1'b0;
			walk_q      <= 1'b0;
			res_valid_q <= 1'b0;
			ok_q        <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && !(step && frame_end)) begin
				res_valid_q <= 1'b0;
			end
			if (step) begin
				if (!in_frame_q) begin
					if (byte_s1 == dfr_pkg::START_BYTE) begin
						in_frame_q <= 1'b1;
						sum_q      <= byte_s1;
						idx_q      <= CTRL_IDX;
					end
				end else if (frame_end) begin
					if (sum_match) begin
						if (dec.hit) begin
							assist_q <= dec.factor;
						end
						lights_q <= ctrl_q[dfr_pkg::LIGHT_BIT];
						walk_q   <= ctrl_q[dfr_pkg::WALK_BIT];
					end
					in_frame_q  <= 1'b0;
					idx_q       <= '0;
					sum_q       <= '0;
					res_valid_q <= 1'b1;
					ok_q        <= sum_match;
				end else begin
					if (idx_q == CTRL_IDX) begin
						ctrl_q <= byte_s1;
					end
					sum_q <= sum_q + byte_s1;
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	// The flag registers always hold the current commands, so they drive
	// the result fields directly.
	assign res_valid         = res_valid_q;
	assign frame_ok          = ok_q;
	assign assist_factor_x10 = assist_q;
	assign lights_on         = lights_q;
	assign walk_assist_on    = walk_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("frame index beyond last byte");

	a_hunt_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> idx_q == '0)
		else $error("frame index not cleared while hunting");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step && frame_end) |=> (res_valid_q && !in_frame_q))
		else $error("frame end did not produce a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid_q && !(step && frame_end)) |=> !res_valid_q)
		else $error("result raised without a completed frame");

	a_factor_code: assert property (@(posedge clk) disable iff (!arst_n)
		assist_q == dfr_pkg::FACTOR_X0 || assist_q == dfr_pkg::FACTOR_X10 ||
		assist_q == dfr_pkg::FACTOR_X20 || assist_q == dfr_pkg::FACTOR_X30 ||
		assist_q == dfr_pkg::FACTOR_X40)
		else $error("assist factor outside its code set");

endmodule
